@@ sv/lpr_pkg.sv @@
// Shared types and constants of the LRU page replacement block.
package lpr_pkg;

  // Width of the page field on the input channel.
  localparam int unsigned PageInW = 16;
  // Width of the frame-limit register.
  localparam int unsigned CfgW = 4;
  // Width of the running fault total.
  localparam int unsigned TotalW = 32;
  // Frame limit after reset.
  localparam logic [CfgW-1:0] FramesReset = 4'd8;

  // Per-reference control broadcast to every cell.
  typedef struct packed {
    logic go;       // apply the pending reference this cycle
    logic hit_any;  // some cell holds the page
    logic fill;     // miss with room: load the first free frame
    logic repl;     // miss without room: replace the least recent frame
  } lpr_ctl_t;

endpackage

@@ sv/lpr_ifs.sv @@
// Valid/ready channel interfaces for page references and fault results.
interface lpr_page_if;
  logic                        valid;
  logic                        ready;
  logic [lpr_pkg::PageInW-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface lpr_result_if;
  logic                       valid;
  logic                       ready;
  logic                       fault;
  logic [lpr_pkg::TotalW-1:0] fault_total;

  modport source (output valid, output fault, output fault_total, input ready);
  modport sink   (input valid, input fault, input fault_total, output ready);
endinterface

@@ sv/lpr_cell.sv @@
// One frame of the LRU tracker: resident page, valid bit and recency rank.
module lpr_cell #(
  parameter int unsigned PAGE_BITS = 16,
  parameter int unsigned RANK_W    = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lpr_pkg::lpr_ctl_t    ctl_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic [RANK_W-1:0]    hit_rank_i,
  input  logic [RANK_W-1:0]    last_rank_i,
  input  logic                 free_i,
  output logic                 free_o,
  output logic                 hit_o,
  output logic [RANK_W-1:0]    rank_o
);

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic [RANK_W-1:0]    rank_q;
  logic                 load;

  assign hit_o  = valid_q && (page_q == page_i);
  assign rank_o = rank_q;
  // A free frame earlier in the row (lower index) already claims the fill.
  assign free_o = free_i | ~valid_q;

  assign load = (ctl_i.fill && !valid_q && !free_i) ||
                (ctl_i.repl && valid_q && (rank_q == last_rank_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (ctl_i.go) begin
      if (ctl_i.hit_any) begin
        if (hit_o) begin
          rank_q <= '0;
        end else if (valid_q && (rank_q < hit_rank_i)) begin
          rank_q <= rank_q + 1'b1;
        end
      end else if (load) begin
        valid_q <= 1'b1;
        rank_q  <= '0;
      end else if (valid_q) begin
        rank_q <= rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.go && !ctl_i.hit_any && load) begin
      page_q <= page_i;
    end
  end

endmodule

@@ sv/lru_page_replacement.sv @@
// Top level of the LRU page replacement tracker: row of frame cells and fault counter.
// An accepted page waits in the pending register until the output register is free;
// it is then applied to the cells and its result registered, held until the sink takes it.
// Throughput: one page per cycle while the sink keeps up; the cell row compares, ages and
// loads as the pending reference is applied, so the next reference sees the updated frames.
// Reset (async, active low): every frame empty, occupancy and fault total zero, limit eight.
module lru_page_replacement #(
  parameter int unsigned NUM_FRAMES = 8,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lpr_page_if.sink                   in_i,
  lpr_result_if.source               out_o,
  input  logic                       cfg_we_i,
  input  logic [lpr_pkg::CfgW-1:0]   cfg_wdata_i
);

  localparam int unsigned RankW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned OccW  = $clog2(NUM_FRAMES + 1);

  // Frame limit register.
  logic [lpr_pkg::CfgW-1:0] cfg_q;
  logic [lpr_pkg::CfgW-1:0] cfg_eff;

  // Pending reference between acceptance and the cell update.
  logic                 pend_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 proc;

  // Bookkeeping.
  logic [OccW-1:0]                occ_q;
  logic [RankW-1:0]               occ_m1;
  logic [lpr_pkg::TotalW-1:0]     fault_cnt_q;
  logic [lpr_pkg::TotalW-1:0]     fault_cnt_d;

  // Output register.
  logic                           out_valid_q;
  logic                           out_fault_q;
  logic [lpr_pkg::TotalW-1:0]     out_total_q;

  // Cell row.
  lpr_pkg::lpr_ctl_t              ctl;
  logic [NUM_FRAMES-1:0]          hit_vec;
  logic [RankW-1:0]               rank_vec [NUM_FRAMES];
  logic [NUM_FRAMES:0]            free_chain;
  logic [RankW-1:0]               hit_rank;
  logic                           room;

  // Configuration: writes land directly in the limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lpr_pkg::FramesReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // A limit of zero acts as one; limits above the frame count are capped by
  // the free-frame chain running dry.
  assign cfg_eff = (cfg_q == '0) ? lpr_pkg::CfgW'(1) : cfg_q;

  // Apply the pending reference whenever the output register can take its
  // result; accept a new beat in the same cycle so the pipe never bubbles.
  assign proc       = pend_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !pend_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      pend_q <= 1'b1;
    end else if (proc) begin
      pend_q <= 1'b0;
    end
  end

  // Mask the page to the tracked width.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      page_q <= PAGE_BITS'(in_i.page);
    end
  end

  // Hits are one-hot (resident pages are distinct), so OR the ranks together.
  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      hit_rank = hit_rank | (hit_vec[i] ? rank_vec[i] : '0);
    end
  end

  // Room to fill: below the limit and some frame still free. Valid frames
  // always form a prefix, so the least recent one carries rank occ-1.
  assign room   = (32'(occ_q) < 32'(cfg_eff)) && free_chain[NUM_FRAMES];
  assign occ_m1 = RankW'(occ_q - 1'b1);

  assign ctl.go      = proc;
  assign ctl.hit_any = |hit_vec;
  assign ctl.fill    = !ctl.hit_any && room;
  assign ctl.repl    = !ctl.hit_any && !room;

  assign free_chain[0] = 1'b0;

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    lpr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .RANK_W    (RankW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .page_i      (page_q),
      .hit_rank_i  (hit_rank),
      .last_rank_i (occ_m1),
      .free_i      (free_chain[g]),
      .free_o      (free_chain[g+1]),
      .hit_o       (hit_vec[g]),
      .rank_o      (rank_vec[g])
    );
  end

  // Saturating fault total: hold at all ones.
  assign fault_cnt_d = (fault_cnt_q == '1) ? fault_cnt_q : fault_cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      fault_cnt_q <= '0;
    end else if (proc && !ctl.hit_any) begin
      fault_cnt_q <= fault_cnt_d;
      if (ctl.fill) begin
        occ_q <= occ_q + 1'b1;
      end
    end
  end

  // Output register: load on apply, drop once the sink takes the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_fault_q <= !ctl.hit_any;
      out_total_q <= ctl.hit_any ? fault_cnt_q : fault_cnt_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.fault       = out_fault_q;
  assign out_o.fault_total = out_total_q;

`ifndef SYNTHESIS
  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |-> $onehot0(hit_vec))
    else $error("more than one frame holds the referenced page");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && ctl.fill) |=> (occ_q == $past(occ_q) + 1'b1))
    else $error("fill did not grow occupancy");

  a_hit_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && ctl.hit_any) |=> ($stable(occ_q) && $stable(fault_cnt_q)))
    else $error("hit changed occupancy or fault total");

  a_fault_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.fault) |-> (out_o.fault_total != '0))
    else $error("fault reported with zero total");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= 32'(NUM_FRAMES))
    else $error("occupancy exceeds frame count");
`endif

endmodule

@@ sim/tb_lru_page_replacement.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the LRU page replacement tracker: directed table, then random traffic.
module tb_lru_page_replacement;

  localparam int unsigned NumFrames = 8;
  localparam int unsigned PageW     = lpr_pkg::PageInW;
  localparam int unsigned RandItems = 1300;
  localparam int unsigned NumPhases = 10;
  localparam int unsigned DrainMax  = 20000;

  typedef enum logic {ROW_PAGE, ROW_LIMIT} row_kind_e;

  // One row of the directed table. Typed rows carry their expected result.
  typedef struct {
    row_kind_e                  kind;
    logic [PageW-1:0]           val;
    bit                         typed;
    logic                       flt;
    logic [lpr_pkg::TotalW-1:0] tot;
  } dir_row_t;

  typedef struct {
    logic                       flt;
    logic [lpr_pkg::TotalW-1:0] tot;
  } fault_res_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [lpr_pkg::CfgW-1:0] cfg_wdata;

  lpr_page_if   pg_ch ();
  lpr_result_if res_ch ();

  lru_page_replacement #(
    .NUM_FRAMES (NumFrames),
    .PAGE_BITS  (PageW)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (pg_ch),
    .out_o       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Mirror of the block: resident pages, recency ranks, occupancy, fault total.
  logic [PageW-1:0]           frm_page [NumFrames];
  bit                         frm_valid[NumFrames];
  logic [2:0]                 frm_rank [NumFrames];
  int unsigned                frm_used;
  logic [lpr_pkg::TotalW-1:0] flt_count;
  logic [lpr_pkg::CfgW-1:0]   frame_limit;

  // Expected fault results, oldest first.
  fault_res_t fault_q[$];
  dir_row_t   dir_rows[$];

  fault_res_t  got_exp;
  int unsigned mismatches;
  int unsigned pages_sent;
  int unsigned results_seen;
  int unsigned faults_seen;
  int unsigned limit_writes;
  bit          idle_en;

  // Free-running clock, 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("timeout: block stopped making progress");
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Age every valid frame ranked below bound, then make frame f the most recent.
  function automatic void promote(input int f, input int unsigned bound);
    for (int i = 0; i < NumFrames; i++)
      if (i != f && frm_valid[i] && frm_rank[i] < bound) frm_rank[i] = frm_rank[i] + 3'd1;
    frm_rank[f] = '0;
  endfunction

  // Apply one page reference to the mirror and return the fault result it causes.
  function automatic fault_res_t lru_reference(input logic [PageW-1:0] pg);
    fault_res_t  res;
    int          hit_f;
    int          slot;
    int          victim;
    int unsigned best;
    int unsigned lim;
    hit_f  = -1;
    slot   = -1;
    victim = -1;
    best   = 0;
    // A limit of zero acts as one; above the frame count it clips to the frame count.
    lim = (frame_limit == 0) ? 1 : ((frame_limit > NumFrames) ? NumFrames : frame_limit);
    for (int i = 0; i < NumFrames; i++)
      if (hit_f < 0 && frm_valid[i] && frm_page[i] == pg) hit_f = i;
    res.flt = 1'b0;
    if (hit_f >= 0) begin
      promote(hit_f, frm_rank[hit_f]);
    end else begin
      res.flt = 1'b1;
      if (flt_count != '1) flt_count = flt_count + 1'b1;
      if (frm_used < lim) begin
        for (int i = 0; i < NumFrames; i++)
          if (slot < 0 && !frm_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        frm_valid[slot] = 1'b1;
        frm_page[slot]  = pg;
        frm_used++;
        frm_rank[slot]  = '0;
        promote(slot, 32'hFFFF_FFFF);
      end else begin
        // Full, or limit lowered below occupancy: replace the least recent valid frame.
        for (int i = 0; i < NumFrames; i++)
          if (frm_valid[i] && (victim < 0 || frm_rank[i] > best)) begin
            best   = frm_rank[i];
            victim = i;
          end
        if (victim < 0) victim = 0;
        frm_page[victim] = pg;
        promote(victim, best);
      end
    end
    res.tot = flt_count;
    return res;
  endfunction

  // Send one page beat; entered and left at a falling edge. Valid stays high on return.
  task automatic send_page(input logic [PageW-1:0] pg, input bit typed,
                           input fault_res_t typed_res);
    fault_res_t pred;
    while (idle_en && $urandom_range(99) < 10) begin
      pg_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    pg_ch.valid <= 1'b1;
    pg_ch.page  <= pg;
    @(posedge clk_i);
    while (!pg_ch.ready) @(posedge clk_i);
    // Beat accepted at this edge: advance the mirror in acceptance order.
    pred = lru_reference(pg);
    fault_q.insert(fault_q.size(), typed ? typed_res : pred);
    pages_sent++;
    @(negedge clk_i);
  endtask

  // Write the frame limit once the block has drained; entered and left at a falling edge.
  task automatic write_limit(input logic [lpr_pkg::CfgW-1:0] v);
    pg_ch.valid <= 1'b0;
    while (fault_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    frame_limit = v;
    limit_writes++;
  endtask

  task automatic add_row(input row_kind_e kind, input logic [PageW-1:0] val, input bit typed,
                         input logic flt, input logic [lpr_pkg::TotalW-1:0] tot);
    dir_row_t r;
    r.kind  = kind;
    r.val   = val;
    r.typed = typed;
    r.flt   = flt;
    r.tot   = tot;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Result sink: stall at random while idling is enabled.
  always @(negedge clk_i) begin
    res_ch.ready <= !idle_en || ($urandom_range(99) >= 10);
  end

  // Compare each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (res_ch.fault === 1'b1) faults_seen++;
      if (fault_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: fault=%0b total=%0d",
                                  res_ch.fault, res_ch.fault_total));
      end else begin
        got_exp = fault_q.pop_front();
        if (res_ch.fault !== got_exp.flt)
          report_mismatch($sformatf("beat %0d fault: got %0b, want %0b",
                                    results_seen, res_ch.fault, got_exp.flt));
        if (res_ch.fault_total !== got_exp.tot)
          report_mismatch($sformatf("beat %0d fault_total: got %0d, want %0d",
                                    results_seen, res_ch.fault_total, got_exp.tot));
      end
    end
  end

  initial begin
    logic [PageW-1:0] pool[12];
    int unsigned      pool_n;
    int unsigned      phase_limit[NumPhases];
    int unsigned      eff;
    int unsigned      drain_cnt;
    fault_res_t       typed_res;
    logic [PageW-1:0] pg;

    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    pg_ch.valid  = 1'b0;
    pg_ch.page   = '0;
    res_ch.ready = 1'b0;
    idle_en      = 1'b1;
    mismatches   = 0;
    pages_sent   = 0;
    results_seen = 0;
    faults_seen  = 0;
    limit_writes = 0;

    // Mirror comes out of reset empty with the default frame limit.
    for (int i = 0; i < NumFrames; i++) begin
      frm_page[i]  = '0;
      frm_valid[i] = 1'b0;
      frm_rank[i]  = '0;
    end
    frm_used    = 0;
    flt_count   = '0;
    frame_limit = lpr_pkg::FramesReset;

    // Directed table: page extremes, hits, limit lowered below occupancy,
    // limit of zero, limit above the frame count, fill then evict.
    add_row(ROW_PAGE,  16'h0000, 1, 1'b1, 32'd1);
    add_row(ROW_PAGE,  16'hFFFF, 1, 1'b1, 32'd2);
    add_row(ROW_PAGE,  16'h0000, 1, 1'b0, 32'd2);
    add_row(ROW_PAGE,  16'hFFFF, 1, 1'b0, 32'd2);
    add_row(ROW_LIMIT, 16'd1,    0, 1'b0, '0);
    add_row(ROW_PAGE,  16'h1234, 1, 1'b1, 32'd3);
    add_row(ROW_PAGE,  16'hFFFF, 0, 1'b0, '0);
    add_row(ROW_PAGE,  16'h0000, 1, 1'b1, 32'd4);
    add_row(ROW_LIMIT, 16'd0,    0, 1'b0, '0);
    add_row(ROW_PAGE,  16'hA5A5, 1, 1'b1, 32'd5);
    add_row(ROW_PAGE,  16'h5A5A, 1, 1'b1, 32'd6);
    add_row(ROW_PAGE,  16'h5A5A, 1, 1'b0, 32'd6);
    add_row(ROW_LIMIT, 16'd15,   0, 1'b0, '0);
    for (int b = 0; b < 9; b++) add_row(ROW_PAGE, 16'(1 << b), 0, 1'b0, '0);
    add_row(ROW_PAGE,  16'h0002, 0, 1'b0, '0);
    add_row(ROW_PAGE,  16'h0001, 0, 1'b0, '0);
    add_row(ROW_LIMIT, 16'd8,    0, 1'b0, '0);

    // Hold reset, then release it on a falling edge.
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_LIMIT) begin
        write_limit(dir_rows[k].val[lpr_pkg::CfgW-1:0]);
      end else begin
        typed_res.flt = dir_rows[k].flt;
        typed_res.tot = dir_rows[k].tot;
        send_page(dir_rows[k].val, dir_rows[k].typed, typed_res);
      end
    end

    // Random phases: each picks a frame limit and a working set a little larger
    // than the limit, so hits, fills and evictions all show up.
    phase_limit = '{8, 1, 15, 3, 0, 6, 2, 8, 12, 5};
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_limit(lpr_pkg::CfgW'(phase_limit[ph]));
      // One long stretch with both sides streaming at full rate.
      idle_en = (ph != 6);
      eff     = (phase_limit[ph] == 0) ? 1 :
                ((phase_limit[ph] > NumFrames) ? NumFrames : phase_limit[ph]);
      pool_n  = eff + $urandom_range(1, 3);
      for (int i = 0; i < pool_n; i++) pool[i] = PageW'($urandom_range(0, 65535));
      for (int n = 0; n < RandItems / NumPhases; n++) begin
        if ($urandom_range(99) < 85) pg = pool[$urandom_range(0, pool_n - 1)];
        else                          pg = PageW'($urandom_range(0, 65535));
        typed_res = '{flt: 1'b0, tot: '0};
        send_page(pg, 0, typed_res);
      end
    end
    idle_en = 1'b1;

    // Drain: stop sending, then wait out the outstanding results.
    pg_ch.valid <= 1'b0;
    drain_cnt = 0;
    while (fault_q.size() != 0 && drain_cnt < DrainMax) begin
      @(posedge clk_i);
      drain_cnt++;
    end
    repeat (4) @(posedge clk_i);
    if (fault_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", fault_q.size()));

    $display("covered %0d page references, %0d faults, %0d hits, %0d frame-limit writes",
             pages_sent, faults_seen, results_seen - faults_seen, limit_writes);
    $display("limits 0..15 exercised incl. zero, over-range and shrink below occupancy");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ lru_page_replacement.f @@
sv/lpr_pkg.sv
sv/lpr_ifs.sv
sv/lpr_cell.sv
sv/lru_page_replacement.sv
sim/tb_lru_page_replacement.sv
